// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// default clk / arst_n
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== hw/rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int PAT_BYTES = 32;
	localparam int CFG_W     = 64;
	localparam int IDX_W     = 3;
	localparam int LEN_W     = 6;

	typedef enum logic [IDX_W-1:0] {
		REG_PAT0   = 3'd0,
		REG_PAT1   = 3'd1,
		REG_PAT2   = 3'd2,
		REG_PAT3   = 3'd3,
		REG_MASK   = 3'd4,
		REG_LENGTH = 3'd5,
		REG_BASE   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_last;
	} in_req_t;

	typedef struct packed {
		logic [63:0] match_address;
		logic        found;
	} out_req_t;

	typedef struct packed {
		logic [PAT_BYTES*8-1:0] pattern;
		logic [PAT_BYTES-1:0]   mask;
		logic [LEN_W-1:0]       length;
		logic [63:0]            base;
	} cfg_t;

	function automatic logic [7:0] pattern_byte(logic [PAT_BYTES*8-1:0] pat, logic [4:0] idx);
		pattern_byte = pat[idx*8 +: 8];
	endfunction

endpackage

// ===== hw/rtl/masked_byte_pattern_scanner_top.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Wildcard byte signature search over a byte stream, one cell per window byte.
//
//   channel  | signals                          | role
//   ---------+----------------------------------+-------------------------------
//   in       | in_valid, in_ready, in_req       | region bytes, last-byte flag
//   out      | out_valid, out_ready, out_req    | match address or not-found
//   cfg      | cfg_we, cfg_addr, cfg_wdata      | register writes, no wait
//
// One byte per cycle while no result is held in stage 1; a result passes
// stage 1, then the output register. Cells compare in the accept cycle, the
// hit AND and base add form the output stage. Reset clears window, counter,
// match flag and registers. A stalled output holds the next result in stage 1
// and stops input; until then, bytes that give no result keep flowing.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top #(
	parameter int PATTERN_MAX = 32,
	parameter int COUNT_BITS  = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mbps_pkg::in_req_t          in_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output mbps_pkg::out_req_t         out_req,
	input  logic                       cfg_we,
	input  logic [mbps_pkg::IDX_W-1:0] cfg_addr,
	input  logic [mbps_pkg::CFG_W-1:0] cfg_wdata
);

	mbps_pkg::cfg_t          cfg;
	logic [7:0]              win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]  hits_s1;

	logic                    accept;
	logic [COUNT_BITS-1:0]   count_q;
	logic [COUNT_BITS-1:0]   count_inc;
	logic [COUNT_BITS-1:0]   len_ext;
	logic                    len_ok;

	logic                    valid_s1;
	logic                    last_s1;
	logic                    lenok_s1;
	logic [COUNT_BITS-1:0]   offset_s1;

	logic                    done_q;
	logic                    out_valid_q;
	mbps_pkg::out_req_t      out_req_q;
	logic                    hit_all;
	logic                    match;
	logic                    not_found;
	logic                    produce;
	logic                    out_free;
	logic                    adv_s1;

	mbps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [7:0] d_in;
		if (k == 0) begin : g_head
			assign d_in = in_req.data_byte;
		end else begin : g_link
			assign d_in = win[k-1];
		end
		mbps_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.clear    (in_req.region_last),
			.d_in     (d_in),
			.cfg      (cfg),
			.d_out    (win[k]),
			.hit_s1   (hits_s1[k])
		);
	end

	assign accept    = in_valid && in_ready;
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign len_ext   = COUNT_BITS'(cfg.length);
	assign len_ok    = (cfg.length != '0)
	                && ({1'b0, cfg.length} <= 7'(PATTERN_MAX))
	                && (count_inc >= len_ext);

	assign hit_all   = lenok_s1 && (&hits_s1);
	assign match     = !done_q && hit_all;
	assign not_found = !done_q && !hit_all && last_s1;
	assign produce   = match || not_found;
	assign out_free  = !out_valid_q || out_ready;
	assign adv_s1    = valid_s1 && (out_free || !produce);
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			count_q  <= in_req.region_last ? '0 : count_inc;
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= in_req.region_last;
			lenok_s1  <= len_ok;
			offset_s1 <= count_inc - len_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				done_q <= last_s1 ? 1'b0 : (done_q || match);
			end
			if (adv_s1 && produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce) begin
			out_req_q.found         <= match;
			out_req_q.match_address <= match ? cfg.base + 64'(offset_s1) : 64'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

endmodule

// ===== hw/rtl/mbps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file: pattern, compare mask, length, region base.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mbps_pkg::IDX_W-1:0] cfg_addr,
	input  logic [mbps_pkg::CFG_W-1:0] cfg_wdata,
	output mbps_pkg::cfg_t             cfg
);

	mbps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				mbps_pkg::REG_PAT0:   cfg_q.pattern[0   +: 64] <= cfg_wdata;
				mbps_pkg::REG_PAT1:   cfg_q.pattern[64  +: 64] <= cfg_wdata;
				mbps_pkg::REG_PAT2:   cfg_q.pattern[128 +: 64] <= cfg_wdata;
				mbps_pkg::REG_PAT3:   cfg_q.pattern[192 +: 64] <= cfg_wdata;
				mbps_pkg::REG_MASK:   cfg_q.mask   <= cfg_wdata[mbps_pkg::PAT_BYTES-1:0];
				mbps_pkg::REG_LENGTH: cfg_q.length <= cfg_wdata[mbps_pkg::LEN_W-1:0];
				mbps_pkg::REG_BASE:   cfg_q.base   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it on, and compares the incoming
// byte against the pattern byte that lands on this position.
// ----------------------------------------------------------------------------
module mbps_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  logic           clear,
	input  logic [7:0]     d_in,
	input  mbps_pkg::cfg_t cfg,
	output logic [7:0]     d_out,
	output logic           hit_s1
);

	logic [7:0] byte_q;
	logic [6:0] pos;
	logic [6:0] sel;
	logic       used;
	logic       hit;

	assign pos  = 7'(IDX);
	assign sel  = {1'b0, cfg.length} - pos - 7'd1;
	assign used = (pos < {1'b0, cfg.length}) && cfg.mask[sel[4:0]];
	assign hit  = !used || (d_in == mbps_pkg::pattern_byte(cfg.pattern, sel[4:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= clear ? 8'd0 : d_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			hit_s1 <= hit;
		end
	end

	assign d_out = byte_q;

endmodule

// ===== hw/rtl/mbps_checker.sv =====
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input mbps_pkg::out_req_t out_req
);

	`ASSERT_STD(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`ASSERT_STD(a_out_stable, out_valid && !out_ready |=> $stable(out_req), "stalled result changed")
	`ASSERT_STD(a_nf_zero, out_valid && !out_req.found |-> out_req.match_address == 64'd0, "not-found with address")
	`ASSERT_CLK(a_rise_src, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without request")

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (.*);
